FILE: rtl/core/rpn_pkg.sv
// rpn_pkg: shared widths, operation codes and status codes for the rpn calculator
// used by rpn_stack_calculator; no dependencies
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_W      = 32;
  localparam int OP_W        = 3;
  localparam int STAT_W      = 2;
  localparam int DEPTH_W     = 5;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(WORD_W);
  localparam int ALU_W       = WORD_W + 1;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - WORD_W - DEPTH_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam op_t OP_PUSH   = 3'd0;
  localparam op_t OP_ADD    = 3'd1;
  localparam op_t OP_SUB    = 3'd2;
  localparam op_t OP_MUL    = 3'd3;
  localparam op_t OP_DIV    = 3'd4;
  localparam op_t OP_FINISH = 3'd5;

  localparam stat_t ST_OK        = 2'd0;
  localparam stat_t ST_OVERFLOW  = 2'd1;
  localparam stat_t ST_UNDERFLOW = 2'd2;
  localparam stat_t ST_DIVZERO   = 2'd3;

endpackage

FILE: rtl/core/rpn_ram.sv
// rpn_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/rpn_stack_calculator.sv
// rpn_stack_calculator: reverse polish integer calculator on a bounded stack
// depends on rpn_pkg and rpn_ram (stack storage)
//
//   channel | direction | fields (low bit up)
//   --------+-----------+-----------------------------------------------------
//   in_     | slave     | tdata: operand_value[31:0]; tuser: operation[2:0]
//   out_    | master    | tdata: result_value[31:0], stack_depth[36:32], pad
//           |           | tuser: status[1:0], pad
//
// multiply and divide run 32 steps of the one shared 33-bit add/subtract unit
// (shift-add, restoring division one quotient bit a step)
// stack words sit in a ram with registered read, so each popped word arrives in
// its own state (S_TOP, then S_SEC)
// reset empties the stack at once; ram contents are left as they are
// in_tready is high only while idle; one finished result waits in the output
// register, so a new transaction is taken while out_ is stalled
module rpn_stack_calculator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rpn_pkg::IN_TDATA_W-1:0]  in_tdata,   // operand_value
  input  logic [rpn_pkg::IN_TUSER_W-1:0]  in_tuser,   // operation, pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rpn_pkg::OUT_TDATA_W-1:0] out_tdata,  // result_value, stack_depth, pad
  output logic [rpn_pkg::OUT_TUSER_W-1:0] out_tuser   // status, pad
);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;   // waiting for a transaction
  localparam logic [3:0] S_TOP  = 4'd1;   // top word arrives from ram
  localparam logic [3:0] S_SEC  = 4'd2;   // second word arrives from ram
  localparam logic [3:0] S_ALU  = 4'd3;   // add or subtract
  localparam logic [3:0] S_MUL  = 4'd4;   // shift-add steps
  localparam logic [3:0] S_NEGA = 4'd5;   // magnitude of dividend
  localparam logic [3:0] S_NEGB = 4'd6;   // magnitude of divisor
  localparam logic [3:0] S_DIV  = 4'd7;   // restoring division steps
  localparam logic [3:0] S_NEGQ = 4'd8;   // apply quotient sign
  localparam logic [3:0] S_PUSH = 4'd9;   // push arithmetic result
  localparam logic [3:0] S_DONE = 4'd10;  // hand result to output register

  logic [3:0]                    state_r, state_nxt;
  logic [rpn_pkg::SP_W-1:0]      sp_r, sp_nxt;
  rpn_pkg::op_t                  op_r, op_nxt;
  rpn_pkg::word_t                a_r, a_nxt;       // second word, multiplicand, dividend/quotient
  rpn_pkg::word_t                b_r, b_nxt;       // top word, multiplier, divisor
  rpn_pkg::word_t                work_r, work_nxt; // product accumulator or partial remainder
  rpn_pkg::word_t                res_r, res_nxt;
  rpn_pkg::stat_t                stat_r, stat_nxt;
  logic [rpn_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          miss_top_r, miss_top_nxt;
  logic                          miss_sec_r, miss_sec_nxt;
  logic                          dz_r, dz_nxt;
  logic                          nneg_r, nneg_nxt;
  logic                          dneg_r, dneg_nxt;

  // output register
  logic                          out_valid_r;
  rpn_pkg::word_t                out_res_r;
  rpn_pkg::stat_t                out_stat_r;
  logic [rpn_pkg::DEPTH_W-1:0]   out_depth_r;
  logic                          out_load;

  // input fields
  rpn_pkg::op_t                  in_op;
  rpn_pkg::word_t                in_val;
  logic                          in_fire;

  // stack ram
  logic                          ram_we;
  logic [rpn_pkg::ADDR_W-1:0]    ram_waddr;
  rpn_pkg::word_t                ram_wdata;
  logic [rpn_pkg::ADDR_W-1:0]    ram_raddr;
  rpn_pkg::word_t                ram_rdata;
  logic [rpn_pkg::SP_W-1:0]      sp_dec;
  logic                          stack_full;

  // shared add/subtract unit
  logic [rpn_pkg::ALU_W-1:0]     alu_a;
  logic [rpn_pkg::ALU_W-1:0]     alu_b;
  logic                          alu_sub;
  logic [rpn_pkg::ALU_W:0]       alu_sum;
  logic                          alu_carry;
  logic [rpn_pkg::ALU_W-1:0]     div_shift;
  rpn_pkg::word_t                q_next;

  assign in_op   = in_tuser[rpn_pkg::OP_W-1:0];
  assign in_val  = in_tdata[rpn_pkg::WORD_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid && in_tready;

  assign sp_dec     = sp_r - rpn_pkg::SP_W'(1);
  assign stack_full = (sp_r >= rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH));
  // read address always points at the current top; the ram registers the data and it shows up in the next cycle
  assign ram_raddr  = sp_dec[rpn_pkg::ADDR_W-1:0];
  assign ram_waddr  = sp_r[rpn_pkg::ADDR_W-1:0];
  assign ram_we     = (in_fire && (in_op == rpn_pkg::OP_PUSH) && !stack_full) ||
                      (state_r == S_PUSH);
  assign ram_wdata  = (state_r == S_PUSH) ? res_r : in_val;

  rpn_ram #(
    .WIDTH (rpn_pkg::WORD_W),
    .DEPTH (rpn_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // operand selection for the shared unit
  assign div_shift = {work_r, a_r[rpn_pkg::WORD_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_ALU: begin
        alu_a   = {1'b0, a_r};
        alu_b   = {1'b0, b_r};
        alu_sub = (op_r == rpn_pkg::OP_SUB);
      end
      S_MUL: begin
        alu_a = {1'b0, work_r};
        alu_b = {1'b0, a_r};
      end
      S_NEGA: begin
        alu_b   = {1'b0, a_r};
        alu_sub = 1'b1;
      end
      S_NEGB: begin
        alu_b   = {1'b0, b_r};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = div_shift;
        alu_b   = {1'b0, b_r};
        alu_sub = 1'b1;
      end
      S_NEGQ: begin
        alu_b   = {1'b0, a_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // a + ~b + 1 for subtract; carry out high means no borrow
  assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {rpn_pkg::ALU_W{alu_sub}}} +
                     {{rpn_pkg::ALU_W{1'b0}}, alu_sub};
  assign alu_carry = alu_sum[rpn_pkg::ALU_W];
  assign q_next    = {a_r[rpn_pkg::WORD_W-2:0], alu_carry};

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    sp_nxt       = sp_r;
    op_nxt       = op_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    work_nxt     = work_r;
    res_nxt      = res_r;
    stat_nxt     = stat_r;
    cnt_nxt      = cnt_r;
    miss_top_nxt = miss_top_r;
    miss_sec_nxt = miss_sec_r;
    dz_nxt       = dz_r;
    nneg_nxt     = nneg_r;
    dneg_nxt     = dneg_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt = in_op;
          dz_nxt = 1'b0;
          if (in_op == rpn_pkg::OP_PUSH) begin
            // push: a full stack drops the value but still echoes it
            res_nxt = in_val;
            if (stack_full) begin
              stat_nxt = rpn_pkg::ST_OVERFLOW;
            end else begin
              stat_nxt = rpn_pkg::ST_OK;
              sp_nxt   = sp_r + rpn_pkg::SP_W'(1);
            end
            state_nxt = S_DONE;
          end else if (in_op inside {[rpn_pkg::OP_ADD:rpn_pkg::OP_FINISH]}) begin
            // pop the top word; ram read of sp-1 is already under way
            if (sp_r != '0) begin
              sp_nxt       = sp_dec;
              miss_top_nxt = 1'b0;
            end else begin
              miss_top_nxt = 1'b1;
            end
            state_nxt = S_TOP;
          end else begin
            // unused codes leave the stack alone
            res_nxt   = '0;
            stat_nxt  = rpn_pkg::ST_OK;
            state_nxt = S_DONE;
          end
        end
      end
      S_TOP: begin
        b_nxt = miss_top_r ? '0 : ram_rdata;
        if (op_r == rpn_pkg::OP_FINISH) begin
          res_nxt   = miss_top_r ? '0 : ram_rdata;
          stat_nxt  = miss_top_r ? rpn_pkg::ST_UNDERFLOW : rpn_pkg::ST_OK;
          state_nxt = S_DONE;
        end else begin
          // pop the second word
          if (sp_r != '0) begin
            sp_nxt       = sp_dec;
            miss_sec_nxt = 1'b0;
          end else begin
            miss_sec_nxt = 1'b1;
          end
          state_nxt = S_SEC;
        end
      end
      S_SEC: begin
        a_nxt    = miss_sec_r ? '0 : ram_rdata;
        nneg_nxt = miss_sec_r ? 1'b0 : ram_rdata[rpn_pkg::WORD_W-1];
        dneg_nxt = b_r[rpn_pkg::WORD_W-1];
        work_nxt = '0;
        cnt_nxt  = rpn_pkg::CNT_W'(rpn_pkg::WORD_W - 1);
        case (op_r)
          rpn_pkg::OP_ADD,
          rpn_pkg::OP_SUB: state_nxt = S_ALU;
          rpn_pkg::OP_MUL: state_nxt = S_MUL;
          rpn_pkg::OP_DIV: begin
            if (b_r == '0) begin
              res_nxt   = '0;
              dz_nxt    = 1'b1;
              state_nxt = S_PUSH;
            end else begin
              state_nxt = S_NEGA;
            end
          end
          default: state_nxt = S_PUSH;
        endcase
      end
      S_ALU: begin
        res_nxt   = alu_sum[rpn_pkg::WORD_W-1:0];
        state_nxt = S_PUSH;
      end
      S_MUL: begin
        // low word of the product: add shifted multiplicand where multiplier bit is set
        if (b_r[0]) begin
          work_nxt = alu_sum[rpn_pkg::WORD_W-1:0];
        end
        a_nxt = {a_r[rpn_pkg::WORD_W-2:0], 1'b0};
        b_nxt = {1'b0, b_r[rpn_pkg::WORD_W-1:1]};
        if (cnt_r == '0) begin
          res_nxt   = b_r[0] ? alu_sum[rpn_pkg::WORD_W-1:0] : work_r;
          state_nxt = S_PUSH;
        end else begin
          cnt_nxt = cnt_r - rpn_pkg::CNT_W'(1);
        end
      end
      S_NEGA: begin
        if (nneg_r) begin
          a_nxt = alu_sum[rpn_pkg::WORD_W-1:0];
        end
        state_nxt = S_NEGB;
      end
      S_NEGB: begin
        if (dneg_r) begin
          b_nxt = alu_sum[rpn_pkg::WORD_W-1:0];
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // remainder stays below the divisor, so it fits one word
        work_nxt = alu_carry ? alu_sum[rpn_pkg::WORD_W-1:0] :
                               div_shift[rpn_pkg::WORD_W-1:0];
        a_nxt    = q_next;
        if (cnt_r == '0) begin
          state_nxt = S_NEGQ;
        end else begin
          cnt_nxt = cnt_r - rpn_pkg::CNT_W'(1);
        end
      end
      S_NEGQ: begin
        res_nxt   = (nneg_r != dneg_r) ? alu_sum[rpn_pkg::WORD_W-1:0] : a_r;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // two pops always leave room for the result
        sp_nxt = sp_r + rpn_pkg::SP_W'(1);
        if (miss_top_r || miss_sec_r) begin
          stat_nxt = rpn_pkg::ST_UNDERFLOW;
        end else if (dz_r) begin
          stat_nxt = rpn_pkg::ST_DIVZERO;
        end else begin
          stat_nxt = rpn_pkg::ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    work_r     <= work_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    cnt_r      <= cnt_nxt;
    miss_top_r <= miss_top_nxt;
    miss_sec_r <= miss_sec_nxt;
    dz_r       <= dz_nxt;
    nneg_r     <= nneg_nxt;
    dneg_r     <= dneg_nxt;
    if (out_load) begin
      out_res_r   <= res_r;
      out_stat_r  <= stat_r;
      out_depth_r <= rpn_pkg::DEPTH_W'(sp_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{rpn_pkg::OUT_PAD_W{1'b0}}, out_depth_r, out_res_r};
  assign out_tuser  = {{(rpn_pkg::OUT_TUSER_W - rpn_pkg::STAT_W){1'b0}}, out_stat_r};

endmodule
